### rtl/ttee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttee_pkg
// shared types and constants of the text terminal escape engine
// ----------------------------------------------------------------------------
package ttee_pkg;

  // byte classes seen in normal mode
  localparam logic [2:0] K_OTHER = 3'd0;
  localparam logic [2:0] K_PRINT = 3'd1;
  localparam logic [2:0] K_ESC   = 3'd2;
  localparam logic [2:0] K_DEL   = 3'd3;
  localparam logic [2:0] K_BS    = 3'd4;
  localparam logic [2:0] K_CR    = 3'd5;
  localparam logic [2:0] K_LF    = 3'd6;

  // parse modes
  localparam logic [1:0] MODE_NORM = 2'd0;
  localparam logic [1:0] MODE_ESC  = 2'd1;
  localparam logic [1:0] MODE_CSI  = 2'd2;

  // operations
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // byte codes
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_SAVE  = 8'h37;
  localparam logic [7:0] CH_REST  = 8'h38;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_J     = 8'h4a;

  // sgr values
  localparam logic [7:0] SGR_FG_LO  = 8'd30;
  localparam logic [7:0] SGR_FG_HI  = 8'd37;
  localparam logic [7:0] SGR_BG_LO  = 8'd40;
  localparam logic [7:0] SGR_BG_HI  = 8'd47;
  localparam logic [7:0] SGR_FG_DEF = 8'd39;
  localparam logic [7:0] SGR_BG_DEF = 8'd49;
  localparam logic [7:0] PARAM_MAX  = 8'd255;
  localparam logic [7:0] ERASE_ALL  = 8'd2;

  localparam logic [3:0]  FG_RST        = 4'd7;
  localparam logic [3:0]  BG_RST        = 4'd0;
  localparam logic [31:0] COLOR_MAP_RST = 32'h7351_6240;
  localparam logic        REG_COLOR_MAP = 1'b0;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic [4:0] read_row;
    logic [6:0] read_col;
    logic [2:0] kind;
    logic       is_digit;
    logic [3:0] digit;
  } cmd_t;

endpackage

### rtl/ttee_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttee channel interfaces
// input word and result word channels with valid/ready
// ----------------------------------------------------------------------------
interface ttee_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  logic [4:0] read_row;
  logic [6:0] read_col;
  modport source (output valid, operation, data_byte, read_row, read_col, input ready);
  modport sink   (input valid, operation, data_byte, read_row, read_col, output ready);
endinterface

interface ttee_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_char;
  logic [3:0] cell_fg;
  logic [3:0] cell_bg;
  logic [4:0] cur_row;
  logic [6:0] cur_col;
  logic [1:0] parse_mode;
  modport source (output valid, cell_char, cell_fg, cell_bg, cur_row, cur_col, parse_mode,
                  input ready);
  modport sink   (input valid, cell_char, cell_fg, cell_bg, cur_row, cur_col, parse_mode,
                  output ready);
endinterface

### rtl/ttee_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttee_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module ttee_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/ttee_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttee_front
// accepts input words and classifies the byte for the back end
// ----------------------------------------------------------------------------
module ttee_front (
  ttee_in_if.sink        in_ch,
  input  logic           full,
  output logic           push,
  output ttee_pkg::cmd_t cmd
);
  import ttee_pkg::*;

  logic [7:0] b;
  assign b = in_ch.data_byte;

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  always_comb begin
    cmd           = '0;
    cmd.op        = in_ch.operation;
    cmd.data_byte = b;
    cmd.read_row  = in_ch.read_row;
    cmd.read_col  = in_ch.read_col;
    cmd.is_digit  = (b >= CH_0) && (b <= CH_9);
    cmd.digit     = 4'(b - CH_0);
    if (b == CH_ESC) begin
      cmd.kind = K_ESC;
    end else if (b == CH_DEL) begin
      cmd.kind = K_DEL;
    end else if (b == CH_BS) begin
      cmd.kind = K_BS;
    end else if (b == CH_CR) begin
      cmd.kind = K_CR;
    end else if (b == CH_LF) begin
      cmd.kind = K_LF;
    end else if (b >= CH_SPACE && b <= CH_TILDE) begin
      cmd.kind = K_PRINT;
    end else begin
      cmd.kind = K_OTHER;
    end
  end
endmodule

### rtl/ttee_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttee_queue
// two-entry queue between front and back end
// ----------------------------------------------------------------------------
module ttee_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ttee_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output ttee_pkg::cmd_t dout
);
  import ttee_pkg::*;

  cmd_t       ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign dout  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wp_r] <= din;
    end
  end
endmodule

### rtl/ttee_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttee_back
// executes terminal commands against the screen store and cursor state
// ----------------------------------------------------------------------------
module ttee_back #(
  parameter int ROWS       = 25,
  parameter int COLS       = 80,
  parameter int MAX_PARAMS = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [31:0]    color_map,
  input  logic           q_valid,
  input  ttee_pkg::cmd_t q_cmd,
  output logic           pop,
  ttee_out_if.source     out_ch
);
  import ttee_pkg::*;

  localparam int N  = ROWS * COLS;
  localparam int AW = $clog2(N);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int PW = $clog2(MAX_PARAMS);
  localparam int NW = $clog2(MAX_PARAMS + 2);

  localparam logic [2:0] ST_FILL   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_SCR_RD = 3'd3;
  localparam logic [2:0] ST_SCR_WR = 3'd4;
  localparam logic [2:0] ST_SGR    = 3'd5;

  logic [2:0]    st_r, st_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          emit_r, emit_nxt;
  logic [RW-1:0] row_r, row_nxt, srow_r, srow_nxt;
  logic [CW-1:0] col_r, col_nxt, scol_r, scol_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [7:0]    val_r [MAX_PARAMS];
  logic [7:0]    val_nxt [MAX_PARAMS];
  logic [NW-1:0] cnt_r, cnt_nxt, left_r, left_nxt;
  logic [3:0]    fg_r, fg_nxt, bg_r, bg_nxt;
  logic          ov_r, ov_nxt;
  logic [15:0]   ocell_r, ocell_nxt;
  logic [4:0]    orow_r, orow_nxt;
  logic [6:0]    ocol_r, ocol_nxt;
  logic [1:0]    omode_r, omode_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata, blank;

  ttee_ram #(.WIDTH(16), .DEPTH(N)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign blank = {bg_r, fg_r, CH_SPACE};

  assign out_ch.valid      = ov_r;
  assign out_ch.cell_char  = ocell_r[7:0];
  assign out_ch.cell_fg    = ocell_r[11:8];
  assign out_ch.cell_bg    = ocell_r[15:12];
  assign out_ch.cur_row    = orow_r;
  assign out_ch.cur_col    = ocol_r;
  assign out_ch.parse_mode = omode_r;

  always_comb begin
    cmd_t          c;
    logic          fin;
    logic [15:0]   fcell;
    logic [RW-1:0] brow;
    logic [CW-1:0] bcol;
    logic [11:0]   prod;
    logic [7:0]    n, p;
    logic [9:0]    sum;
    logic [NW-1:0] cn;
    logic [2:0]    ci;
    c        = q_cmd;
    fin      = 1'b0;
    fcell    = '0;
    brow     = row_r;
    bcol     = col_r;
    prod     = '0;
    n        = '0;
    p        = val_r[0];
    sum      = '0;
    cn       = cnt_r;
    ci       = '0;
    st_nxt   = st_r;
    idx_nxt  = idx_r;
    emit_nxt = emit_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    srow_nxt = srow_r;
    scol_nxt = scol_r;
    mode_nxt = mode_r;
    val_nxt  = val_r;
    cnt_nxt  = cnt_r;
    left_nxt = left_r;
    fg_nxt   = fg_r;
    bg_nxt   = bg_r;
    pop      = 1'b0;
    we       = 1'b0;
    waddr    = idx_r;
    wdata    = blank;
    raddr    = AW'(int'(idx_r) + COLS);
    ov_nxt   = (ov_r && out_ch.ready) ? 1'b0 : ov_r;

    case (st_r)
      ST_FILL: begin
        we = 1'b1;
        if (int'(idx_r) == N - 1) begin
          st_nxt = ST_IDLE;
          fin    = emit_r;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_SCR_RD: begin
        st_nxt = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        we    = 1'b1;
        wdata = rdata;
        if (int'(idx_r) == (ROWS - 1) * COLS - 1) begin
          idx_nxt  = AW'((ROWS - 1) * COLS);
          emit_nxt = 1'b1;
          st_nxt   = ST_FILL;
        end else begin
          idx_nxt = idx_r + 1'b1;
          st_nxt  = ST_SCR_RD;
        end
      end
      ST_READ: begin
        fin    = 1'b1;
        fcell  = rdata;
        st_nxt = ST_IDLE;
      end
      ST_SGR: begin
        ci = 3'(p - SGR_FG_LO);
        if (p >= SGR_FG_LO && p <= SGR_FG_HI) begin
          fg_nxt = color_map[4*ci +: 4];
        end else if (p >= SGR_BG_LO && p <= SGR_BG_HI) begin
          ci     = 3'(p - SGR_BG_LO);
          bg_nxt = color_map[4*ci +: 4];
        end else if (p == SGR_FG_DEF) begin
          fg_nxt = FG_RST;
        end else if (p == SGR_BG_DEF) begin
          bg_nxt = BG_RST;
        end
        for (int i = 0; i < MAX_PARAMS - 1; i++) begin
          val_nxt[i] = val_r[i+1];
        end
        val_nxt[MAX_PARAMS-1] = '0;
        left_nxt = left_r - 1'b1;
        if (left_r == NW'(1)) begin
          fin    = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid && !ov_r) begin
          pop = 1'b1;
          if (c.op == OP_READ) begin
            if (int'(c.read_row) < ROWS && int'(c.read_col) < COLS) begin
              raddr  = AW'(int'(c.read_row) * COLS + int'(c.read_col));
              st_nxt = ST_READ;
            end else begin
              fin = 1'b1;
            end
          end else begin
            case (mode_r)
              MODE_NORM: begin
                fin = 1'b1;
                // position one cell back, for bs and del
                if (col_r != '0) begin
                  bcol = col_r - 1'b1;
                end else begin
                  brow = row_r - 1'b1;
                  bcol = CW'(COLS - 1);
                end
                case (c.kind)
                  K_ESC: mode_nxt = MODE_ESC;
                  K_DEL: begin
                    if (col_r != '0 || row_r != '0) begin
                      we      = 1'b1;
                      waddr   = AW'(int'(brow) * COLS + int'(bcol));
                      row_nxt = brow;
                      col_nxt = bcol;
                    end
                  end
                  K_BS: begin
                    if (col_r != '0 || row_r != '0) begin
                      row_nxt = brow;
                      col_nxt = bcol;
                    end
                  end
                  K_CR: col_nxt = '0;
                  K_LF: begin
                    col_nxt = '0;
                    if (int'(row_r) == ROWS - 1) begin
                      fin     = 1'b0;
                      idx_nxt = '0;
                      st_nxt  = ST_SCR_RD;
                    end else begin
                      row_nxt = row_r + 1'b1;
                    end
                  end
                  K_PRINT: begin
                    we    = 1'b1;
                    waddr = AW'(int'(row_r) * COLS + int'(col_r));
                    wdata = {bg_r, fg_r, c.data_byte};
                    if (int'(col_r) == COLS - 1) begin
                      col_nxt = '0;
                      if (int'(row_r) == ROWS - 1) begin
                        fin     = 1'b0;
                        idx_nxt = '0;
                        st_nxt  = ST_SCR_RD;
                      end else begin
                        row_nxt = row_r + 1'b1;
                      end
                    end else begin
                      col_nxt = col_r + 1'b1;
                    end
                  end
                  default: ;
                endcase
              end
              MODE_ESC: begin
                fin      = 1'b1;
                mode_nxt = MODE_NORM;
                if (c.data_byte == CH_SAVE) begin
                  srow_nxt = row_r;
                  scol_nxt = col_r;
                end else if (c.data_byte == CH_REST) begin
                  row_nxt = srow_r;
                  col_nxt = scol_r;
                end else if (c.data_byte == CH_LBRK) begin
                  for (int i = 0; i < MAX_PARAMS; i++) begin
                    val_nxt[i] = '0;
                  end
                  cnt_nxt  = '0;
                  mode_nxt = MODE_CSI;
                end
              end
              MODE_CSI: begin
                fin = 1'b1;
                if (c.is_digit) begin
                  if (int'(cnt_r) < MAX_PARAMS) begin
                    prod = 12'(val_r[cnt_r[PW-1:0]]) * 12'd10 + 12'(c.digit);
                    val_nxt[cnt_r[PW-1:0]] = (prod > 12'(PARAM_MAX)) ? PARAM_MAX : prod[7:0];
                  end
                end else if (c.data_byte == CH_SEMI && int'(cnt_r) < MAX_PARAMS) begin
                  cnt_nxt = cnt_r + 1'b1;
                end else begin
                  if (int'(cnt_r) <= MAX_PARAMS) begin
                    cn = cnt_r + 1'b1;
                  end
                  cnt_nxt  = cn;
                  mode_nxt = MODE_NORM;
                  n        = (val_r[0] == '0) ? 8'd1 : val_r[0];
                  case (c.data_byte)
                    CH_M: begin
                      fin      = 1'b0;
                      left_nxt = (int'(cn) < MAX_PARAMS) ? cn : NW'(MAX_PARAMS);
                      st_nxt   = ST_SGR;
                    end
                    CH_D: begin
                      col_nxt = (9'(col_r) >= 9'(n)) ? CW'(9'(col_r) - 9'(n)) : '0;
                    end
                    CH_C: begin
                      sum     = 10'(col_r) + 10'(n);
                      col_nxt = (int'(sum) >= COLS) ? CW'(COLS - 1) : CW'(sum);
                    end
                    CH_H, CH_F: begin
                      row_nxt = (int'(val_r[0]) >= ROWS) ? RW'(ROWS - 1) : RW'(val_r[0]);
                      if (cn >= NW'(2)) begin
                        col_nxt = (int'(val_r[1]) >= COLS) ? CW'(COLS - 1)
                                                           : CW'(val_r[1]);
                      end
                    end
                    CH_J: begin
                      if (val_r[0] == ERASE_ALL) begin
                        fin      = 1'b0;
                        row_nxt  = '0;
                        col_nxt  = '0;
                        idx_nxt  = '0;
                        emit_nxt = 1'b1;
                        st_nxt   = ST_FILL;
                      end
                    end
                    default: ;
                  endcase
                end
              end
              default: begin
                fin      = 1'b1;
                mode_nxt = MODE_NORM;
              end
            endcase
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase

    ocell_nxt = ocell_r;
    orow_nxt  = orow_r;
    ocol_nxt  = ocol_r;
    omode_nxt = omode_r;
    if (fin) begin
      ov_nxt    = 1'b1;
      ocell_nxt = fcell;
      orow_nxt  = 5'(row_nxt);
      ocol_nxt  = 7'(col_nxt);
      omode_nxt = mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_FILL;
      idx_r  <= '0;
      emit_r <= 1'b0;
      row_r  <= '0;
      col_r  <= '0;
      srow_r <= '0;
      scol_r <= '0;
      mode_r <= MODE_NORM;
      cnt_r  <= '0;
      left_r <= '0;
      fg_r   <= FG_RST;
      bg_r   <= BG_RST;
      ov_r   <= 1'b0;
      for (int i = 0; i < MAX_PARAMS; i++) begin
        val_r[i] <= '0;
      end
    end else begin
      st_r   <= st_nxt;
      idx_r  <= idx_nxt;
      emit_r <= emit_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      srow_r <= srow_nxt;
      scol_r <= scol_nxt;
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      left_r <= left_nxt;
      fg_r   <= fg_nxt;
      bg_r   <= bg_nxt;
      ov_r   <= ov_nxt;
      val_r  <= val_nxt;
    end
    ocell_r <= ocell_nxt;
    orow_r  <= orow_nxt;
    ocol_r  <= ocol_nxt;
    omode_r <= omode_nxt;
  end
endmodule

### rtl/text_terminal_escape_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_escape_engine_unit
// character-cell text terminal with an ansi escape parser
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one word per item: a write feeds data_byte to the terminal,
//   a read returns the screen cell at read_row/read_col. every item gives one
//   word on out_ch with the cell (zero on writes), the cursor and parse mode.
//   the color map register sits at byte address 0 of the apb-style cfg port.
// flow
//   a word goes through a two-entry queue; plain and escape bytes are done
//   when the back end takes them up, a read passes through the read state,
//   and an sgr final byte applies its params one by one in the sgr state.
//   a scroll copies the store one cell at a time, each through a read state
//   and a write state, then blanks the last row; erase-all blanks the store.
//   these sweeps run on the single write / single read port of the store.
// reset
//   after reset the store is blanked, one cell a cycle;
//   input words are queued meanwhile but not executed.
// stall
//   the result register holds while out_ch.ready is low; the queue keeps
//   taking input words until it holds two.
// ----------------------------------------------------------------------------
module text_terminal_escape_engine_unit #(
  parameter int ROWS       = 25,
  parameter int COLS       = 80,
  parameter int MAX_PARAMS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  ttee_in_if.sink     in_ch,
  ttee_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ttee_pkg::*;

  // configuration register
  logic [31:0] color_map_r, color_map_nxt;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_COLOR_MAP) ? color_map_r : '0;

  always_comb begin
    color_map_nxt = color_map_r;
    if (cfg_wr && cfg_paddr[2] == REG_COLOR_MAP) begin
      color_map_nxt = cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_map_r <= COLOR_MAP_RST;
    end else begin
      color_map_r <= color_map_nxt;
    end
  end

  // front end: accept and classify
  cmd_t push_cmd, q_cmd;
  logic push, full, pop, q_valid;

  ttee_front u_front (
    .in_ch(in_ch),
    .full (full),
    .push (push),
    .cmd  (push_cmd)
  );

  // decoupling queue
  ttee_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .din  (push_cmd),
    .full (full),
    .pop  (pop),
    .valid(q_valid),
    .dout (q_cmd)
  );

  // back end: screen store, cursor, parser state, result register
  ttee_back #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .MAX_PARAMS(MAX_PARAMS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .color_map(color_map_r),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  // back end only takes a word that the queue holds
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
    else $error("pop from empty queue");

  // a new word is only started while the result register is free
  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !out_ch.valid)
    else $error("word started while result pending");

  // a stalled result blocks the back end on the next cycle
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
      (out_ch.valid && !out_ch.ready) |=> !pop)
    else $error("back end ran past a stalled result");

  // no result right after reset, the store is still being blanked
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result during reset");
endmodule

### verif/text_terminal_escape_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_escape_engine_unit_tb
// self-checking bench: a directed burst of terminal bytes and cell reads,
// then random text, escape sequences, control bytes and reads over several
// color map settings; every result word is checked against a local model
// of the screen, cursor and escape parser
// ----------------------------------------------------------------------------
module text_terminal_escape_engine_unit_tb;
  import ttee_pkg::*;

  localparam int NROWS     = 25;
  localparam int NCOLS     = 80;
  localparam int NPARAMS   = 10;
  localparam int N_RANDOM  = 1500;
  localparam int IDLE_LIMIT = 40000;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [3:0] cell_fg;
    logic [3:0] cell_bg;
    logic [4:0] cur_row;
    logic [6:0] cur_col;
    logic [1:0] parse_mode;
  } term_word_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } term_item_t;

  // --------------------------------------------------------------------------
  // terminal scoreboard: shadow screen, cursor and parser, expected words
  // --------------------------------------------------------------------------
  class term_scoreboard;
    logic [15:0]  screen[NROWS*NCOLS];
    int unsigned  row, col, save_row, save_col, count;
    logic [1:0]   mode;
    int unsigned  params[NPARAMS];
    logic [3:0]   fg, bg;
    logic [31:0]  color_map;
    term_word_t   pending[$];
    int           errors, checked, scrolls;

    function new();
      row = 0; col = 0; save_row = 0; save_col = 0; count = 0;
      mode = MODE_NORM; fg = FG_RST; bg = BG_RST; color_map = COLOR_MAP_RST;
      errors = 0; checked = 0; scrolls = 0;
      foreach (params[i]) params[i] = 0;
      foreach (screen[i]) screen[i] = {BG_RST, FG_RST, CH_SPACE};
    endfunction

    function logic [15:0] paint(logic [7:0] ch);
      return {bg, fg, ch};
    endfunction

    function void roll_screen();
      for (int i = 0; i < (NROWS-1)*NCOLS; i++) screen[i] = screen[i+NCOLS];
      for (int i = (NROWS-1)*NCOLS; i < NROWS*NCOLS; i++) screen[i] = paint(CH_SPACE);
      row = NROWS-1;
      scrolls++;
    endfunction

    function void line_down();
      row++;
      if (row >= NROWS) roll_screen();
    endfunction

    function void store_char(logic [7:0] ch);
      screen[row*NCOLS + col] = paint(ch);
      col++;
      if (col >= NCOLS) begin
        col = 0;
        line_down();
      end
    endfunction

    function bit back_up();
      if (col > 0) begin
        col--;
        return 1;
      end
      if (row > 0) begin
        row--;
        col = NCOLS-1;
        return 1;
      end
      return 0;
    endfunction

    function logic [3:0] palette(int unsigned idx);
      return color_map[4*(idx%8) +: 4];
    endfunction

    function void plain_byte(logic [7:0] b);
      if (b == CH_ESC) mode = MODE_ESC;
      else if (b == CH_DEL) begin
        if (back_up()) begin
          store_char(CH_SPACE);
          void'(back_up());
        end
      end else if (b == CH_BS) void'(back_up());
      else if (b == CH_CR) col = 0;
      else if (b == CH_LF) begin
        col = 0;
        line_down();
      end else if (b >= CH_SPACE && b <= CH_TILDE) store_char(b);
    endfunction

    function void escape_byte(logic [7:0] b);
      mode = MODE_NORM;
      if (b == CH_SAVE) begin
        save_row = row; save_col = col;
      end else if (b == CH_REST) begin
        row = save_row; col = save_col;
      end else if (b == CH_LBRK) begin
        foreach (params[i]) params[i] = 0;
        count = 0;
        mode = MODE_CSI;
      end
    endfunction

    function void csi_byte(logic [7:0] b);
      int unsigned n, lim, p;
      if (b >= CH_0 && b <= CH_9) begin
        if (count < NPARAMS) begin
          p = params[count]*10 + (b - CH_0);
          params[count] = (p > PARAM_MAX) ? PARAM_MAX : p;
        end
        return;
      end
      if (b == CH_SEMI && count < NPARAMS) begin
        count++;
        return;
      end
      if (count <= NPARAMS) count++;
      mode = MODE_NORM;
      n = (params[0] != 0) ? params[0] : 1;
      case (b)
        CH_M: begin
          lim = (count < NPARAMS) ? count : NPARAMS;
          for (int i = 0; i < lim; i++) begin
            p = params[i];
            if (p >= SGR_FG_LO && p <= SGR_FG_HI) fg = palette(p - SGR_FG_LO);
            else if (p >= SGR_BG_LO && p <= SGR_BG_HI) bg = palette(p - SGR_BG_LO);
            else if (p == SGR_FG_DEF) fg = FG_RST;
            else if (p == SGR_BG_DEF) bg = BG_RST;
          end
        end
        CH_D: col = (col >= n) ? col - n : 0;
        CH_C: col = (col + n >= NCOLS) ? NCOLS-1 : col + n;
        CH_H, CH_F: begin
          if (count >= 1) row = (params[0] >= NROWS) ? NROWS-1 : params[0];
          if (count >= 2) col = (params[1] >= NCOLS) ? NCOLS-1 : params[1];
        end
        CH_J: begin
          if (count >= 1 && params[0] == ERASE_ALL) begin
            foreach (screen[i]) screen[i] = paint(CH_SPACE);
            row = 0; col = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_input(term_item_t it);
      term_word_t w;
      logic [15:0] rd_cell;
      rd_cell = '0;
      if (it.op == OP_WRITE) begin
        if (mode == MODE_NORM) plain_byte(it.data_byte);
        else if (mode == MODE_ESC) escape_byte(it.data_byte);
        else csi_byte(it.data_byte);
      end else if (it.read_row < NROWS && it.read_col < NCOLS) begin
        rd_cell = screen[it.read_row*NCOLS + it.read_col];
      end
      w.cell_char = rd_cell[7:0];
      w.cell_fg = rd_cell[11:8];
      w.cell_bg = rd_cell[15:12];
      w.cur_row = row[4:0];
      w.cur_col = col[6:0];
      w.parse_mode = mode;
      pending.push_back(w);
    endfunction

    function void check_result(term_word_t got);
      term_word_t exp_w;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      checked++;
      if (got.cell_char !== exp_w.cell_char) begin
        $error("cell_char exp %0h got %0h", exp_w.cell_char, got.cell_char); errors++;
      end
      if (got.cell_fg !== exp_w.cell_fg) begin
        $error("cell_fg exp %0h got %0h", exp_w.cell_fg, got.cell_fg); errors++;
      end
      if (got.cell_bg !== exp_w.cell_bg) begin
        $error("cell_bg exp %0h got %0h", exp_w.cell_bg, got.cell_bg); errors++;
      end
      if (got.cur_row !== exp_w.cur_row) begin
        $error("cur_row exp %0d got %0d", exp_w.cur_row, got.cur_row); errors++;
      end
      if (got.cur_col !== exp_w.cur_col) begin
        $error("cur_col exp %0d got %0d", exp_w.cur_col, got.cur_col); errors++;
      end
      if (got.parse_mode !== exp_w.parse_mode) begin
        $error("parse_mode exp %0d got %0d", exp_w.parse_mode, got.parse_mode); errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, block under test
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ttee_in_if  in_ch ();
  ttee_out_if out_ch ();

  always #5 clk = ~clk;

  text_terminal_escape_engine_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch.sink),
    .out_ch     (out_ch.source),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  term_scoreboard sb = new();
  term_item_t     plan[$];   // words waiting to be sent
  bit             no_idle;   // stretches with no gaps and no stalls
  bit             word_moved;
  int             idle_cycles;
  int             rx_wait;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_WRITE;
    in_ch.data_byte = '0;
    in_ch.read_row = '0;
    in_ch.read_col = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 17);
  endfunction

  // --------------------------------------------------------------------------
  // result side: random stalls, every accepted word goes to the scoreboard
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result({out_ch.cell_char, out_ch.cell_fg, out_ch.cell_bg,
                         out_ch.cur_row, out_ch.cur_col, out_ch.parse_mode});
        rx_wait = draw_gap();
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ch.ready <= (rx_wait == 0);
    end
  end

  // watchdog: too long without any word moving
  always @(posedge clk) begin
    word_moved = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready);
    if (word_moved) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus building
  // --------------------------------------------------------------------------
  function automatic void add_byte(logic [7:0] b);
    term_item_t it;
    it.op = OP_WRITE;
    it.data_byte = b;
    it.read_row = 5'($urandom);
    it.read_col = 7'($urandom);
    plan.push_back(it);
  endfunction

  function automatic void add_read(int r, int c);
    term_item_t it;
    it.op = OP_READ;
    it.data_byte = 8'($urandom);
    it.read_row = 5'(r);
    it.read_col = 7'(c);
    plan.push_back(it);
  endfunction

  function automatic void add_number(int v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // random csi sequence, biased toward useful parameters per final byte
  function automatic void add_csi();
    logic [7:0] fin;
    int n, v, pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: fin = CH_M;
      3:       fin = CH_C;
      4:       fin = CH_D;
      5:       fin = CH_H;
      6:       fin = CH_F;
      7:       fin = CH_J;
      8:       fin = CH_SEMI;
      default: fin = 8'($urandom);
    endcase
    add_byte(CH_ESC);
    add_byte(CH_LBRK);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 13) : $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if (i > 0) add_byte(CH_SEMI);
      if ($urandom_range(0, 7) == 0) continue;  // empty parameter
      if (fin == CH_M) v = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 400)
                                                       : $urandom_range(30, 49);
      else if (fin == CH_J) v = ($urandom_range(0, 5) == 0) ? 2 : $urandom_range(0, 3);
      else v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 999) : $urandom_range(0, 90);
      add_number(v);
    end
    add_byte(fin);
  endfunction

  function automatic void add_random(int target);
    int k;
    while (plan.size() < target) begin
      k = $urandom_range(0, 99);
      if (k < 35) begin
        repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
      end else if (k < 52) add_csi();
      else if (k < 58) begin
        add_byte(CH_ESC);
        case ($urandom_range(0, 2))
          0: add_byte(CH_SAVE);
          1: add_byte(CH_REST);
          default: add_byte(8'($urandom));
        endcase
      end else if (k < 61) add_byte(CH_LF);
      else if (k < 67) begin
        case ($urandom_range(0, 2))
          0: add_byte(CH_CR);
          1: add_byte(CH_BS);
          default: repeat ($urandom_range(1, 4)) add_byte(CH_DEL);
        endcase
      end else if (k < 71) add_byte(8'($urandom));
      else if (k < 95) add_read($urandom_range(0, NROWS-1), $urandom_range(0, NCOLS-1));
      else add_read($urandom_range(0, 31), $urandom_range(0, 127));
    end
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic send_plan();
    term_item_t it;
    int gap;
    while (plan.size() > 0) begin
      it = plan.pop_front();
      if (plan.size() % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
      gap = draw_gap();
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.operation <= it.op;
      in_ch.data_byte <= it.data_byte;
      in_ch.read_row <= it.read_row;
      in_ch.read_col <= it.read_col;
      do @(posedge clk); while (!in_ch.ready);
      sb.note_input(it);
    end
    in_ch.valid <= 1'b0;
  endtask

  // hold input until every expected word has come back, then let it settle
  task automatic drain();
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_color_map(logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {1'b0, REG_COLOR_MAP, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.color_map = v;
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] maps[4];
    no_idle = 1'b0;
    rx_wait = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: edges of the bytes, home backspace, colors, clamps, erase
    add_byte(CH_DEL);                  // erase at home does nothing
    add_byte(CH_BS);                   // backspace at home does nothing
    add_byte(8'h00);                   // ignored control byte
    add_byte(8'hff);                   // ignored high byte
    add_byte(CH_SPACE);
    add_byte(CH_TILDE);
    add_byte(CH_CR);
    add_byte(CH_LF);
    add_byte(CH_BS);                   // wraps to the last column above
    add_byte(CH_ESC); add_byte(CH_SAVE);
    add_byte(CH_ESC); add_byte(8'h80); // unknown byte after escape
    add_byte(CH_ESC); add_byte(CH_LBRK);
    add_number(31); add_byte(CH_SEMI); add_number(42); add_byte(CH_M);
    add_byte(8'h41);                   // colored char
    add_read(1, 0);
    add_byte(CH_ESC); add_byte(CH_LBRK); add_number(999); add_byte(CH_C);
    add_byte(CH_ESC); add_byte(CH_LBRK); add_byte(CH_D);
    add_byte(CH_ESC); add_byte(CH_LBRK); add_number(30); add_byte(CH_SEMI);
    add_number(100); add_byte(CH_H);   // both coordinates clamp
    add_byte(CH_ESC); add_byte(CH_REST);
    add_read(31, 127);                 // out of range read
    add_read(NROWS-1, NCOLS-1);
    // too many parameters: digits past the limit, then a stray separator
    add_byte(CH_ESC); add_byte(CH_LBRK);
    repeat (NPARAMS) add_byte(CH_SEMI);
    add_byte(CH_9); add_byte(CH_SEMI);
    add_byte(CH_ESC); add_byte(CH_LBRK); add_number(39); add_byte(CH_SEMI);
    add_number(49); add_byte(CH_M);
    add_byte(CH_ESC); add_byte(CH_LBRK); add_number(2); add_byte(CH_J);
    add_byte(CH_ESC); add_byte(CH_LBRK); add_number(24); add_byte(CH_H);
    repeat (NCOLS) add_byte(8'h5a);    // fill the bottom row and scroll
    add_read(NROWS-2, 3);
    send_plan();
    drain();

    // random phases, each under its own color map
    maps[0] = 32'h0000_0000;
    maps[1] = 32'hffff_ffff;
    maps[2] = $urandom;
    maps[3] = COLOR_MAP_RST;
    for (int p = 0; p < 4; p++) begin
      write_color_map(maps[p]);
      add_random(N_RANDOM / 4);
      send_plan();
      drain();
    end

    $display("checked %0d result words over 4 color maps, %0d scrolls in the model",
             sb.checked, sb.scrolls);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
